/* rtl/signed_int64_to_decimal_ascii_assert.svh */
// assertion macros for the decimal text block
`ifndef SIGNED_INT64_TO_DECIMAL_ASCII_ASSERT_SVH
`define SIGNED_INT64_TO_DECIMAL_ASCII_ASSERT_SVH

// same-cycle implication, checked out of reset
`define S2D_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("s2d check failed");

// next-cycle implication, checked out of reset
`define S2D_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("s2d check failed");

`endif

/* rtl/s2d_pkg.sv */
`default_nettype none

package s2d_pkg;

	localparam int VALUE_W     = 64;
	localparam int CHAR_W      = 6;
	localparam int IN_TDATA_W  = 64;
	localparam int OUT_TDATA_W = 8;
	localparam int DIGIT_W     = 4;
	localparam int NUM_DIGITS  = 20;
	localparam int BIT_CNT_W   = $clog2(VALUE_W);
	localparam int REM_W       = $clog2(NUM_DIGITS + 1);

	localparam logic [CHAR_W-1:0]  CHAR_MINUS = CHAR_W'(45);
	localparam logic [CHAR_W-1:0]  CHAR_ZERO  = CHAR_W'(48);
	localparam logic [CHAR_W-1:0]  CHAR_NINE  = CHAR_W'(57);
	localparam logic [DIGIT_W-1:0] BCD_ADJ_MIN = DIGIT_W'(5);
	localparam logic [DIGIT_W-1:0] BCD_ADJ     = DIGIT_W'(3);

	typedef struct packed {
		logic clr;
		logic conv;
		logic move;
	} s2d_cell_ctrl_t;

endpackage

`default_nettype wire

/* rtl/s2d_cell.sv */
`default_nettype none

module s2d_cell
	import s2d_pkg::*;
(
	input  wire logic                 clk,
	input  wire s2d_cell_ctrl_t       ctrl,
	input  wire logic                 bit_in,
	input  wire logic [DIGIT_W-1:0]   digit_in,
	output logic                      bit_out,
	output logic [DIGIT_W-1:0]        digit
);

	logic [DIGIT_W-1:0] digit_q;
	logic [DIGIT_W-1:0] adj;

	// add three before the shift when the digit would overflow
	assign adj     = (digit_q >= BCD_ADJ_MIN) ? (digit_q + BCD_ADJ) : digit_q;
	assign bit_out = adj[DIGIT_W-1];
	assign digit   = digit_q;

	always_ff @(posedge clk) begin
		if (ctrl.clr) begin
			digit_q <= '0;
		end else if (ctrl.conv) begin
			digit_q <= {adj[DIGIT_W-2:0], bit_in};
		end else if (ctrl.move) begin
			digit_q <= digit_in;
		end
	end

endmodule

`default_nettype wire

/* rtl/s2d_ctrl.sv */
`default_nettype none

module s2d_ctrl
	import s2d_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [VALUE_W-1:0]   in_value,
	input  wire logic [DIGIT_W-1:0]   top_digit,
	output logic                      mag_bit,
	output s2d_cell_ctrl_t            cell_ctrl,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [CHAR_W-1:0]         out_char,
	output logic                      out_last
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_CONV = 5'b00010,
		ST_SKIP = 5'b00100,
		ST_SIGN = 5'b01000,
		ST_EMIT = 5'b10000
	} s2d_state_t;

	s2d_state_t              state_q, state_d;
	logic [VALUE_W-1:0]      mag_q;
	logic                    neg_q;
	logic [BIT_CNT_W-1:0]    bit_cnt_q;
	logic [REM_W-1:0]        rem_q;
	logic                    out_valid_q;
	logic [CHAR_W-1:0]       char_q;
	logic                    last_q;
	logic                    adv;
	logic                    emit;
	logic [CHAR_W-1:0]       emit_char;
	logic                    emit_last;
	logic                    accept;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign adv       = !out_valid_q || out_ready;
	assign mag_bit   = mag_q[VALUE_W-1];
	assign out_valid = out_valid_q;
	assign out_char  = char_q;
	assign out_last  = last_q;

	always_comb begin
		state_d   = state_q;
		cell_ctrl = '0;
		emit      = 1'b0;
		emit_char = CHAR_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, top_digit};
		emit_last = (rem_q == REM_W'(1));
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cell_ctrl.clr = 1'b1;
					state_d       = ST_CONV;
				end
			end
			ST_CONV: begin
				cell_ctrl.conv = 1'b1;
				if (bit_cnt_q == '0) begin
					state_d = ST_SKIP;
				end
			end
			ST_SKIP: begin
				// drop leading zeros, keep at least one digit
				if (top_digit == '0 && rem_q > REM_W'(1)) begin
					cell_ctrl.move = 1'b1;
				end else begin
					state_d = neg_q ? ST_SIGN : ST_EMIT;
				end
			end
			ST_SIGN: begin
				if (adv) begin
					emit      = 1'b1;
					emit_char = CHAR_MINUS;
					emit_last = 1'b0;
					state_d   = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (adv) begin
					emit           = 1'b1;
					cell_ctrl.move = 1'b1;
					if (rem_q == REM_W'(1)) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			neg_q       <= 1'b0;
			bit_cnt_q   <= '0;
			rem_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				neg_q     <= in_value[VALUE_W-1];
				bit_cnt_q <= BIT_CNT_W'(VALUE_W - 1);
				rem_q     <= REM_W'(NUM_DIGITS);
			end else begin
				if (cell_ctrl.conv) begin
					bit_cnt_q <= bit_cnt_q - BIT_CNT_W'(1);
				end
				if (cell_ctrl.move) begin
					rem_q <= rem_q - REM_W'(1);
				end
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mag_q <= in_value[VALUE_W-1] ? (~in_value + VALUE_W'(1)) : in_value;
		end else if (cell_ctrl.conv) begin
			mag_q <= {mag_q[VALUE_W-2:0], 1'b0};
		end
		if (emit) begin
			char_q <= emit_char;
			last_q <= emit_last;
		end
	end

endmodule

`default_nettype wire

/* rtl/signed_int64_to_decimal_ascii.sv */
// channel   dir  tdata                       tuser  tlast
// s_axis    in   [63:0] value (signed)       -      -
// m_axis    out  [5:0] character, [7:6] 0    -      last character of the number
//
// an item is loaded, then its magnitude is shifted by double dabble through the
// row of twenty digit cells; leading zeros are then skipped and the digits
// handed out, with a minus sign ahead of them for a negative value
// asynchronous active-low reset returns to idle with the output empty
// m_axis_tready low holds the character in the output register and stalls the cells
// while they hand out digits; the next item is taken while the last character still waits
`default_nettype none

module signed_int64_to_decimal_ascii
	import s2d_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     s_axis_tvalid,
	output logic                          s_axis_tready,
	input  wire logic [IN_TDATA_W-1:0]    s_axis_tdata,   // [63:0] value
	output logic                          m_axis_tvalid,
	input  wire logic                     m_axis_tready,
	output logic [OUT_TDATA_W-1:0]        m_axis_tdata,   // [5:0] character
	output logic                          m_axis_tlast
);

	s2d_cell_ctrl_t        cell_ctrl;
	logic                  mag_bit;
	logic [CHAR_W-1:0]     out_char;
	logic [DIGIT_W-1:0]    digit_w [NUM_DIGITS];
	logic [NUM_DIGITS-1:0] carry_w;

	s2d_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_value  (s_axis_tdata[VALUE_W-1:0]),
		.top_digit (digit_w[NUM_DIGITS-1]),
		.mag_bit   (mag_bit),
		.cell_ctrl (cell_ctrl),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_char  (out_char),
		.out_last  (m_axis_tlast)
	);

	for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
		if (i == 0) begin : g_first
			s2d_cell u_cell (
				.clk      (clk),
				.ctrl     (cell_ctrl),
				.bit_in   (mag_bit),
				.digit_in ({DIGIT_W{1'b0}}),
				.bit_out  (carry_w[i]),
				.digit    (digit_w[i])
			);
		end else begin : g_next
			s2d_cell u_cell (
				.clk      (clk),
				.ctrl     (cell_ctrl),
				.bit_in   (carry_w[i-1]),
				.digit_in (digit_w[i-1]),
				.bit_out  (carry_w[i]),
				.digit    (digit_w[i])
			);
		end
	end

	assign m_axis_tdata = {{(OUT_TDATA_W-CHAR_W){1'b0}}, out_char};

endmodule

`default_nettype wire

/* rtl/s2d_checker.sv */
`default_nettype none
`include "signed_int64_to_decimal_ascii_assert.svh"

module s2d_checker
	import s2d_pkg::*;
(
	input wire logic                     clk,
	input wire logic                     arst_n,
	input wire logic                     s_axis_tvalid,
	input wire logic                     s_axis_tready,
	input wire logic                     m_axis_tvalid,
	input wire logic                     m_axis_tready,
	input wire logic [OUT_TDATA_W-1:0]   m_axis_tdata,
	input wire logic                     m_axis_tlast
);

	logic [CHAR_W-1:0]    ch;
	logic [OUT_TDATA_W:0] out_item;
	logic                 ch_ok;

	assign ch       = m_axis_tdata[CHAR_W-1:0];
	assign out_item = {m_axis_tlast, m_axis_tdata};
	assign ch_ok    = (m_axis_tdata[OUT_TDATA_W-1:CHAR_W] == '0)
		&& (ch == CHAR_MINUS || (ch >= CHAR_ZERO && ch <= CHAR_NINE));

	// stalled item holds
	`S2D_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(out_item))

	// only a minus sign or a digit ever appears
	`S2D_ASSERT_NOW(a_char_range, m_axis_tvalid, ch_ok)

	// a minus sign is never the whole text
	`S2D_ASSERT_NOW(a_minus_not_last, m_axis_tvalid && ch == CHAR_MINUS, !m_axis_tlast)

	// conversion runs after an item is taken, input closed meanwhile
	`S2D_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)

endmodule

bind signed_int64_to_decimal_ascii s2d_checker u_s2d_checker (.*);

`default_nettype wire

/* tb/tb_signed_int64_to_decimal_ascii.sv */
`timescale 1ns / 100ps

module tb_signed_int64_to_decimal_ascii;
	import s2d_pkg::*;

	typedef struct {
		logic [CHAR_W-1:0] ch;
		logic              last;
		int                number;
	} char_expect_t;

	class decimal_text_scoreboard;
		char_expect_t pending_chars[$];
		int mismatches;
		int numbers_noted;
		int negatives_noted;
		int chars_checked;
		int longest_text;

		function new();
			mismatches = 0;
			numbers_noted = 0;
			negatives_noted = 0;
			chars_checked = 0;
			longest_text = 0;
		endfunction

		task report(string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			mismatches++;
		endtask

		// decimal text of one signed value, most significant character first
		function void note_value(logic [VALUE_W-1:0] value_bits);
			logic [VALUE_W-1:0] mag;
			logic [CHAR_W-1:0]  text_chars[$];
			char_expect_t       e;
			mag = value_bits[VALUE_W-1] ? (~value_bits + 1'b1) : value_bits;
			do begin
				text_chars.push_front(CHAR_ZERO + CHAR_W'(mag % 64'd10));
				mag = mag / 64'd10;
			end while (mag != 0);
			if (value_bits[VALUE_W-1]) begin
				text_chars.push_front(CHAR_MINUS);
				negatives_noted++;
			end
			foreach (text_chars[i]) begin
				e.ch = text_chars[i];
				e.last = (i == text_chars.size() - 1);
				e.number = numbers_noted;
				pending_chars.push_back(e);
			end
			if (text_chars.size() > longest_text)
				longest_text = text_chars.size();
			numbers_noted++;
		endfunction

		task check_char(logic [OUT_TDATA_W-1:0] tdata, logic tlast);
			char_expect_t e;
			if (pending_chars.size() == 0) begin
				report($sformatf("character %0d with none expected", tdata));
				return;
			end
			e = pending_chars.pop_front();
			chars_checked++;
			if (tdata[CHAR_W-1:0] !== e.ch)
				report($sformatf("number %0d: character %0d, expected %0d",
					e.number, tdata[CHAR_W-1:0], e.ch));
			if (tdata[OUT_TDATA_W-1:CHAR_W] !== '0)
				report($sformatf("number %0d: pad bits %b not zero",
					e.number, tdata[OUT_TDATA_W-1:CHAR_W]));
			if (tlast !== e.last)
				report($sformatf("number %0d: last %b, expected %b",
					e.number, tlast, e.last));
		endtask

		function int pending();
			return pending_chars.size();
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;    // [63:0] value
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;         // [5:0] character, [7:6] zero
	logic                   m_axis_tlast;

	decimal_text_scoreboard text_sb = new();
	int burst_left = 0;
	int stall_mode = 0;
	int cycle_count = 0;
	logic [7:0] stall_pattern = 8'hFF;

	signed_int64_to_decimal_ascii dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("timeout");
		$display("*** FAILED ***");
		$finish;
	end

	// receiver stalls, switching between patterns
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count % 400 == 0) begin
			stall_mode <= $urandom_range(0, 3);
			stall_pattern <= 8'($urandom_range(1, 255));
		end
		case (stall_mode)
			0: m_axis_tready <= 1'b1;
			1: m_axis_tready <= ($urandom_range(0, 3) != 0);
			2: m_axis_tready <= ($urandom_range(0, 3) == 0);
			default: m_axis_tready <= stall_pattern[cycle_count % 8];
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			text_sb.check_char(m_axis_tdata, m_axis_tlast);
	end

	function automatic logic [63:0] pow10(int k);
		logic [63:0] p;
		p = 64'd1;
		repeat (k) p = p * 64'd10;
		return p;
	endfunction

	task automatic push_value(input logic [63:0] v);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 10);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 120);
			if (gap != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= v;
		do @(posedge clk); while (!s_axis_tready);
		text_sb.note_value(v);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (text_sb.pending() != 0) @(posedge clk);
	endtask

	function automatic logic [63:0] random_value();
		logic [63:0] mag;
		logic        neg;
		neg = $urandom_range(0, 1);
		case ($urandom_range(0, 3))
			0: return {$urandom, $urandom};
			1: mag = {$urandom, $urandom} % pow10($urandom_range(1, 19));
			2: mag = 64'($urandom_range(0, 1000));
			default: mag = pow10($urandom_range(0, 18)) + 64'($urandom_range(0, 2)) - 64'd1;
		endcase
		return neg ? -mag : mag;
	endfunction

	initial begin
		logic [63:0] directed[$];
		directed = '{64'd0, 64'd1, -64'd1, 64'd9, -64'd9, 64'd10, -64'd10, 64'd99,
			64'd100, -64'd100, 64'd1234567890,
			64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0001,
			64'd999999999999999999, 64'd1000000000000000000,
			-64'd1000000000000000000, 64'h5555_5555_5555_5555,
			64'hAAAA_AAAA_AAAA_AAAA, 64'd1000000000, -64'd4294967296};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) push_value(directed[i]);
		drain();

		for (int i = 0; i < 350; i++) begin
			push_value(random_value());
			if (i == 175)
				drain();
		end
		drain();
		repeat (120) @(posedge clk);

		$display("converted %0d numbers (%0d negative), %0d characters checked",
			text_sb.numbers_noted, text_sb.negatives_noted, text_sb.chars_checked);
		$display("longest text %0d characters, %0d mismatches",
			text_sb.longest_text, text_sb.mismatches);
		if (text_sb.mismatches == 0 && text_sb.pending() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

/* sim.f */
+incdir+rtl
rtl/s2d_pkg.sv
rtl/s2d_cell.sv
rtl/s2d_ctrl.sv
rtl/signed_int64_to_decimal_ascii.sv
rtl/s2d_checker.sv
tb/tb_signed_int64_to_decimal_ascii.sv
